// ===== hdl/pixel_color_adjust_core_assert.svh =====
// assertion macros for the pixel color adjust core
// no dependencies; included by the rtl files that carry assertions
`ifndef PIXEL_COLOR_ADJUST_CORE_ASSERT_SVH
`define PIXEL_COLOR_ADJUST_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PCA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pca_pkg.sv =====
// types, register indexes and fixed-point constants for the pixel color adjust core
// no dependencies
package pca_pkg;

    typedef enum logic [2:0] {
        MODE_BRIGHT    = 3'd0,
        MODE_CONTRAST  = 3'd1,
        MODE_SATURATE  = 3'd2,
        MODE_INV_RGB   = 3'd3,
        MODE_INV_ALPHA = 3'd4,
        MODE_GRAY601   = 3'd5,
        MODE_LUMA709   = 3'd6,
        MODE_SEPIA     = 3'd7
    } t_mode;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd2;

    localparam logic [11:0] GAIN_RESET = 12'd256;

    // widths of the datapath
    localparam int SUM_W  = 25;  // q9.16 weighted sum of three bytes
    localparam int MUL_W  = 26;  // signed c * 2^16 - sum
    localparam int PROD_W = 38;  // gain * multiplicand
    localparam int ACC_W  = 39;  // sum * 2^8 + product

    // contrast pivot 128 in q9.16, reuses the saturation datapath
    localparam logic [SUM_W-1:0] CONTRAST_PIVOT = 25'h080_0000;

    // weights, unsigned q0.16
    localparam logic [15:0] W709_R = 16'd13933;
    localparam logic [15:0] W709_G = 16'd46871;
    localparam logic [15:0] W709_B = 16'd4732;
    localparam logic [15:0] W601_R = 16'd19589;
    localparam logic [15:0] W601_G = 16'd38470;
    localparam logic [15:0] W601_B = 16'd7471;

    typedef logic [15:0] t_wrow [3];
    localparam t_wrow SEPIA_W [3] = '{
        '{16'd25756, 16'd50397, 16'd12386},
        '{16'd22872, 16'd44958, 16'd11010},
        '{16'd17826, 16'd34996, 16'd8585}
    };

    function automatic logic [SUM_W-1:0] dot3(
        input logic [15:0] w0, input logic [15:0] w1, input logic [15:0] w2,
        input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2);
        logic [SUM_W-1:0] s;
        s = SUM_W'(w0) * SUM_W'(c0) + SUM_W'(w1) * SUM_W'(c1)
            + SUM_W'(w2) * SUM_W'(c2);
        return s;
    endfunction

    function automatic logic [7:0] clamp_byte(input logic signed [15:0] v);
        logic [7:0] r;
        if (v < 16'sd0) begin
            r = 8'd0;
        end else if (v > 16'sd255) begin
            r = 8'd255;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/pixel_color_adjust_core.sv =====
// pixel color adjust core: four-stage rgba point operation selected by mode
// depends on pca_pkg and pixel_color_adjust_core_assert.svh
//
// an accepted pixel passes stages 1 to 4 in order; stage 4 is the output register
// throughput: one pixel per cycle when not stalled; the 12x26 gain multiply has its own stage
// reset (i_rst_n low, synchronous): pipeline emptied, mode 0, offset 0, gain 256
`include "pixel_color_adjust_core_assert.svh"

module pixel_color_adjust_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [pca_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pca_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input pixel channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_red_in,
    input  logic [7:0]                     i_green_in,
    input  logic [7:0]                     i_blue_in,
    input  logic [7:0]                     i_alpha_in,
    // output pixel channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_red_out,
    output logic [7:0]                     o_green_out,
    output logic [7:0]                     o_blue_out,
    output logic [7:0]                     o_alpha_out
);

    // configuration registers
    pca_pkg::t_mode     r_mode;
    logic signed [8:0]  r_offset;
    logic signed [11:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= pca_pkg::MODE_BRIGHT;
            r_offset <= '0;
            r_gain   <= pca_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pca_pkg::REG_MODE:   r_mode   <= pca_pkg::t_mode'(i_cfg_data[2:0]);
                pca_pkg::REG_OFFSET: r_offset <= i_cfg_data[8:0];
                pca_pkg::REG_GAIN:   r_gain   <= i_cfg_data;
                default: begin
                    // index beyond the register list is ignored
                end
            endcase
        end
    end

    // pipeline flow control: a stage loads when it is empty or the next one loads
    logic r_v1, r_v2, r_v3, r_v4;
    logic adv1, adv2, adv3, adv4;

    assign adv4    = !r_v4 || !i_stall;
    assign adv3    = !r_v3 || adv4;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
            if (adv4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // stage 1: weighted sums; contrast uses a constant pivot so that it shares
    // the saturation formula floor((sum * 2^8 + gain * (c * 2^16 - sum)) / 2^24)
    logic [7:0]                  c_in [3];
    logic [pca_pkg::SUM_W-1:0]   n_sum1 [3];
    logic [pca_pkg::SUM_W-1:0]   l709, l601;
    logic [7:0]                  r_c1 [3];
    logic [7:0]                  r_a1;
    logic [pca_pkg::SUM_W-1:0]   r_sum1 [3];
    pca_pkg::t_mode              r_mode1;

    assign c_in[0] = i_red_in;
    assign c_in[1] = i_green_in;
    assign c_in[2] = i_blue_in;

    always_comb begin
        l709 = pca_pkg::dot3(pca_pkg::W709_R, pca_pkg::W709_G, pca_pkg::W709_B,
                             c_in[0], c_in[1], c_in[2]);
        l601 = pca_pkg::dot3(pca_pkg::W601_R, pca_pkg::W601_G, pca_pkg::W601_B,
                             c_in[0], c_in[1], c_in[2]);
        for (int i = 0; i < 3; i++) begin
            case (r_mode)
                pca_pkg::MODE_CONTRAST: n_sum1[i] = pca_pkg::CONTRAST_PIVOT;
                pca_pkg::MODE_SATURATE: n_sum1[i] = l709;
                pca_pkg::MODE_LUMA709:  n_sum1[i] = l709;
                pca_pkg::MODE_GRAY601:  n_sum1[i] = l601;
                pca_pkg::MODE_SEPIA: begin
                    n_sum1[i] = pca_pkg::dot3(pca_pkg::SEPIA_W[i][0],
                        pca_pkg::SEPIA_W[i][1], pca_pkg::SEPIA_W[i][2],
                        c_in[0], c_in[1], c_in[2]);
                end
                default: n_sum1[i] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_c1    <= c_in;
            r_a1    <= i_alpha_in;
            r_sum1  <= n_sum1;
            r_mode1 <= r_mode;
        end
    end

    // stage 2: multiplicand c * 2^16 - sum
    logic signed [pca_pkg::MUL_W-1:0] n_m2 [3];
    logic signed [pca_pkg::MUL_W-1:0] r_m2 [3];
    logic [7:0]                       r_c2 [3];
    logic [7:0]                       r_a2;
    logic [pca_pkg::SUM_W-1:0]        r_sum2 [3];
    pca_pkg::t_mode                   r_mode2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_m2[i] = $signed({2'b00, r_c1[i], 16'h0000}) - $signed({1'b0, r_sum1[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_m2    <= n_m2;
            r_c2    <= r_c1;
            r_a2    <= r_a1;
            r_sum2  <= r_sum1;
            r_mode2 <= r_mode1;
        end
    end

    // stage 3: gain multiply
    logic signed [pca_pkg::PROD_W-1:0] n_p3 [3];
    logic signed [pca_pkg::PROD_W-1:0] r_p3 [3];
    logic [7:0]                        r_c3 [3];
    logic [7:0]                        r_a3;
    logic [pca_pkg::SUM_W-1:0]         r_sum3 [3];
    pca_pkg::t_mode                    r_mode3;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_p3[i] = r_gain * r_m2[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_p3    <= n_p3;
            r_c3    <= r_c2;
            r_a3    <= r_a2;
            r_sum3  <= r_sum2;
            r_mode3 <= r_mode2;
        end
    end

    // stage 4: accumulate, floor, clamp and select by mode into the output register
    logic signed [pca_pkg::ACC_W-1:0] acc [3];
    logic [7:0]                       n_ch [3];
    logic [7:0]                       n_alpha;
    logic signed [9:0]                bright [3];
    logic [7:0]                       r_ch4 [3];
    logic [7:0]                       r_alpha4;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i]    = $signed({6'b000000, r_sum3[i], 8'h00})
                        + pca_pkg::ACC_W'(r_p3[i]);
            bright[i] = $signed({2'b00, r_c3[i]}) + 10'(r_offset);
            case (r_mode3)
                pca_pkg::MODE_BRIGHT:
                    n_ch[i] = pca_pkg::clamp_byte(16'(bright[i]));
                pca_pkg::MODE_CONTRAST, pca_pkg::MODE_SATURATE:
                    // keep the sign of the floored sum so negatives clamp to zero
                    n_ch[i] = pca_pkg::clamp_byte(
                        16'($signed(acc[i][pca_pkg::ACC_W-1:24])));
                pca_pkg::MODE_INV_RGB:
                    n_ch[i] = ~r_c3[i];
                pca_pkg::MODE_INV_ALPHA:
                    n_ch[i] = r_c3[i];
                default:
                    // grayscale, luminance and sepia: floor of the q9.16 sum
                    n_ch[i] = pca_pkg::clamp_byte($signed({7'b0000000, r_sum3[i][24:16]}));
            endcase
        end
        n_alpha = (r_mode3 == pca_pkg::MODE_INV_ALPHA) ? ~r_a3 : r_a3;
    end

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_ch4    <= n_ch;
            r_alpha4 <= n_alpha;
        end
    end

    assign o_red_out   = r_ch4[0];
    assign o_green_out = r_ch4[1];
    assign o_blue_out  = r_ch4[2];
    assign o_alpha_out = r_alpha4;

    // back-pressure only reaches the input when every stage holds a transaction
    `PCA_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_stall,
        r_v1 && r_v2 && r_v3 && r_v4 && i_stall, "input stalled with a free stage")

    // a transaction leaving stage 3 lands in the output register
    `PCA_ASSERT_NEXT(a_stage3_moves, i_clk, i_rst_n, r_v3 && adv4, o_valid,
        "stage 3 transaction lost")

    // no output appears from an empty pipeline
    `PCA_ASSERT_NEXT(a_no_invent, i_clk, i_rst_n, !r_v3 && !r_v4, !o_valid,
        "output valid without a source transaction")

    // alpha passes untouched outside alpha-invert mode
    `PCA_ASSERT_NEXT(a_alpha_pass, i_clk, i_rst_n,
        r_v3 && adv4 && (r_mode3 != pca_pkg::MODE_INV_ALPHA),
        o_alpha_out == $past(r_a3), "alpha changed outside alpha invert")

endmodule

// ===== tb/sv/tb_pixel_color_adjust_core.sv =====
// self-checking testbench for pixel_color_adjust_core: directed corners, then random pixel streams
// predicts every output pixel from its own integer model of the eight color modes
// depends on pca_pkg and the rtl of pixel_color_adjust_core
module tb_pixel_color_adjust_core;
    timeunit 1ns;
    timeprecision 1ps;

    // write index past the register list, must be ignored by the core
    localparam logic [pca_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // margin after the last expected pixel before touching registers
    localparam int DRAIN_CYCLES = 8;
    // slowest run: ~1650 pixels, each waiting out the longest sender gap and receiver stall
    localparam int unsigned LIMIT_CYCLES = 400000;

    // luma and sepia weights, unsigned q0.16
    localparam longint BT709_R = 13933;
    localparam longint BT709_G = 46871;
    localparam longint BT709_B = 4732;
    localparam longint BT601_R = 19589;
    localparam longint BT601_G = 38470;
    localparam longint BT601_B = 7471;
    localparam longint SEP_RR = 25756;
    localparam longint SEP_RG = 50397;
    localparam longint SEP_RB = 12386;
    localparam longint SEP_GR = 22872;
    localparam longint SEP_GG = 44958;
    localparam longint SEP_GB = 11010;
    localparam longint SEP_BR = 17826;
    localparam longint SEP_BG = 34996;
    localparam longint SEP_BB = 8585;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_rgba;

    // dut inputs, all known from time zero
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [pca_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [pca_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                           i_valid     = 1'b0;
    logic [7:0]                     i_red_in    = '0;
    logic [7:0]                     i_green_in  = '0;
    logic [7:0]                     i_blue_in   = '0;
    logic [7:0]                     i_alpha_in  = '0;
    logic                           i_stall     = 1'b0;

    // dut outputs
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_red_out;
    logic [7:0] o_green_out;
    logic [7:0] o_blue_out;
    logic [7:0] o_alpha_out;

    // register shadow, as the core should hold it
    pca_pkg::t_mode     cfg_mode   = pca_pkg::MODE_BRIGHT;
    logic signed [8:0]  cfg_offset = 9'sd0;
    logic signed [11:0] cfg_gain   = 12'sd256;

    // predicted pixels, oldest first
    t_rgba       expected_pixels[$];
    int          mismatches  = 0;
    int unsigned cycle_count = 0;

    // idle bursts on the sender and the receiver
    bit src_idle_on  = 1'b0;
    bit sink_idle_on = 1'b0;

    pixel_color_adjust_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .i_alpha_in  (i_alpha_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_alpha_out (o_alpha_out)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // color model
    // ---------------------------------------------------------------

    function automatic logic [7:0] clip_to_byte(input longint v);
        logic [7:0] r;
        if (v < 0) begin
            r = 8'd0;
        end else if (v > 255) begin
            r = 8'd255;
        end else begin
            r = 8'(v);
        end
        return r;
    endfunction

    // weighted sum of three channels in q9.16
    function automatic longint weigh3(input longint w0, input longint w1, input longint w2,
                                      input longint c0, input longint c1, input longint c2);
        return w0 * c0 + w1 * c1 + w2 * c2;
    endfunction

    // output pixel for one input pixel under the current register shadow
    function automatic t_rgba adjust_pixel(input t_rgba px);
        longint ch[3];
        longint v[3];
        longint lum;
        longint g;
        longint off;
        t_rgba  res;
        ch[0] = longint'(px.red);
        ch[1] = longint'(px.green);
        ch[2] = longint'(px.blue);
        g     = longint'(cfg_gain);
        off   = longint'(cfg_offset);
        res.alpha = px.alpha;
        case (cfg_mode)
            pca_pkg::MODE_BRIGHT: begin
                for (int i = 0; i < 3; i++) v[i] = ch[i] + off;
            end
            pca_pkg::MODE_CONTRAST: begin
                // gain about the 128 pivot, floored by the arithmetic shift
                for (int i = 0; i < 3; i++) v[i] = ((g * (ch[i] - 128)) >>> 8) + 128;
            end
            pca_pkg::MODE_SATURATE: begin
                // gain about the bt.709 luma, all in q9.16 times q4.8
                lum = weigh3(BT709_R, BT709_G, BT709_B, ch[0], ch[1], ch[2]);
                for (int i = 0; i < 3; i++)
                    v[i] = (lum * 256 + g * (ch[i] * 65536 - lum)) >>> 24;
            end
            pca_pkg::MODE_INV_RGB: begin
                for (int i = 0; i < 3; i++) v[i] = 255 - ch[i];
            end
            pca_pkg::MODE_INV_ALPHA: begin
                for (int i = 0; i < 3; i++) v[i] = ch[i];
                res.alpha = 8'd255 - px.alpha;
            end
            pca_pkg::MODE_GRAY601: begin
                lum = weigh3(BT601_R, BT601_G, BT601_B, ch[0], ch[1], ch[2]) >>> 16;
                for (int i = 0; i < 3; i++) v[i] = lum;
            end
            pca_pkg::MODE_LUMA709: begin
                lum = weigh3(BT709_R, BT709_G, BT709_B, ch[0], ch[1], ch[2]) >>> 16;
                for (int i = 0; i < 3; i++) v[i] = lum;
            end
            default: begin
                // sepia matrix, white saturates the red and green rows
                v[0] = weigh3(SEP_RR, SEP_RG, SEP_RB, ch[0], ch[1], ch[2]) >>> 16;
                v[1] = weigh3(SEP_GR, SEP_GG, SEP_GB, ch[0], ch[1], ch[2]) >>> 16;
                v[2] = weigh3(SEP_BR, SEP_BG, SEP_BB, ch[0], ch[1], ch[2]) >>> 16;
            end
        endcase
        res.red   = clip_to_byte(v[0]);
        res.green = clip_to_byte(v[1]);
        res.blue  = clip_to_byte(v[2]);
        return res;
    endfunction

    // ---------------------------------------------------------------
    // driving
    // ---------------------------------------------------------------

    // called at a rising edge; returns at a rising edge, after the write has taken effect
    task automatic write_reg(input logic [pca_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pca_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        // only the low bits of each register survive
        case (idx)
            pca_pkg::REG_MODE:   cfg_mode   = pca_pkg::t_mode'(data[2:0]);
            pca_pkg::REG_OFFSET: cfg_offset = data[8:0];
            pca_pkg::REG_GAIN:   cfg_gain   = data[11:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // one input transaction; entered and left at a rising edge
    task automatic send_pixel(input t_rgba px);
        int gap;
        bit stalled;
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_red_in   <= px.red;
        i_green_in <= px.green;
        i_blue_in  <= px.blue;
        i_alpha_in <= px.alpha;
        // o_stall is settled by the falling edge, and holds until the next rising one
        do begin
            @(negedge i_clk);
            stalled = (o_stall !== 1'b0);
            @(posedge i_clk);
        end while (stalled);
        expected_pixels.push_back(adjust_pixel(px));
    endtask

    // stop sending and let the pipeline run empty
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // full register set, junk in the unused upper bits of mode and offset
    task automatic apply_setting(input pca_pkg::t_mode m, input logic [8:0] off,
                                 input logic [11:0] g);
        wait_drained();
        write_reg(pca_pkg::REG_MODE, {9'($urandom), m});
        write_reg(pca_pkg::REG_OFFSET, {3'($urandom), off});
        write_reg(pca_pkg::REG_GAIN, g);
    endtask

    function automatic logic [7:0] rand_channel();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0:       c = 8'd0;
            1:       c = 8'd255;
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    function automatic t_rgba rand_pixel();
        t_rgba px;
        px.red   = rand_channel();
        px.green = rand_channel();
        px.blue  = rand_channel();
        px.alpha = rand_channel();
        return px;
    endfunction

    // mostly moderate gains, sometimes the full q4.8 range or its ends
    function automatic logic [11:0] rand_gain();
        logic [11:0] g;
        case ($urandom_range(0, 5))
            0:       g = 12'($urandom);
            1:       g = ($urandom_range(0, 1) != 0) ? 12'h7FF : 12'h800;
            default: g = 12'(int'($urandom_range(0, 1024)) - 256);
        endcase
        return g;
    endfunction

    // receiver: random stall bursts
    initial begin
        int burst;
        forever begin
            @(posedge i_clk);
            if (sink_idle_on && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 13);
                i_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        mismatches++;
    endtask

    // i_stall and the outputs are stable from the falling edge until the
    // rising edge that accepts the output transaction
    always @(negedge i_clk) begin : check_output
        t_rgba want;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("output transaction with nothing pending, red", o_red_out, -1);
            end else begin
                want = expected_pixels.pop_front();
                if (o_red_out !== want.red)     report_mismatch("red", o_red_out, want.red);
                if (o_green_out !== want.green) report_mismatch("green", o_green_out, want.green);
                if (o_blue_out !== want.blue)   report_mismatch("blue", o_blue_out, want.blue);
                if (o_alpha_out !== want.alpha) report_mismatch("alpha", o_alpha_out, want.alpha);
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset state is brightness with zero offset: pixels pass through
    task automatic test_reset_values();
        send_pixel({8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel({8'd255, 8'd255, 8'd255, 8'd255});
        send_pixel({8'd1, 8'd128, 8'd254, 8'd127});
    endtask

    // largest positive offset, then the 0x100 and 0x101 patterns read as -256 and -255
    task automatic test_brightness();
        apply_setting(pca_pkg::MODE_BRIGHT, 9'h0FF, 12'd256);
        send_pixel({8'd0, 8'd128, 8'd255, 8'd7});
        apply_setting(pca_pkg::MODE_BRIGHT, 9'h100, 12'd256);
        send_pixel({8'd0, 8'd128, 8'd255, 8'd200});
        apply_setting(pca_pkg::MODE_BRIGHT, 9'h101, 12'd256);
        send_pixel({8'd255, 8'd254, 8'd1, 8'd0});
    endtask

    // extreme gains, the negative one reflects about 128
    task automatic test_contrast();
        apply_setting(pca_pkg::MODE_CONTRAST, 9'd0, 12'h7FF);
        send_pixel({8'd0, 8'd128, 8'd255, 8'd33});
        send_pixel({8'd127, 8'd129, 8'd200, 8'd90});
        apply_setting(pca_pkg::MODE_CONTRAST, 9'd0, 12'h800);
        send_pixel({8'd0, 8'd128, 8'd255, 8'd66});
    endtask

    // zero gain collapses to luma, the extremes clamp
    task automatic test_saturation();
        apply_setting(pca_pkg::MODE_SATURATE, 9'd0, 12'd0);
        send_pixel({8'd255, 8'd0, 8'd128, 8'd1});
        apply_setting(pca_pkg::MODE_SATURATE, 9'd0, 12'h7FF);
        send_pixel({8'd255, 8'd0, 8'd128, 8'd2});
        apply_setting(pca_pkg::MODE_SATURATE, 9'd0, 12'h800);
        send_pixel({8'd200, 8'd100, 8'd10, 8'd3});
    endtask

    task automatic test_inversions();
        apply_setting(pca_pkg::MODE_INV_RGB, 9'd0, 12'd256);
        send_pixel({8'd0, 8'd128, 8'd255, 8'd0});
        apply_setting(pca_pkg::MODE_INV_ALPHA, 9'd0, 12'd256);
        send_pixel({8'd0, 8'd128, 8'd255, 8'd0});
        send_pixel({8'd17, 8'd34, 8'd51, 8'd255});
    endtask

    // grayscale, luminance and sepia at black, white and a warm color
    task automatic test_luma_modes();
        apply_setting(pca_pkg::MODE_GRAY601, 9'd0, 12'd256);
        send_pixel({8'd255, 8'd255, 8'd255, 8'd9});
        send_pixel({8'd0, 8'd0, 8'd0, 8'd9});
        apply_setting(pca_pkg::MODE_LUMA709, 9'd0, 12'd256);
        send_pixel({8'd255, 8'd255, 8'd255, 8'd10});
        apply_setting(pca_pkg::MODE_SEPIA, 9'd0, 12'd256);
        send_pixel({8'd255, 8'd255, 8'd255, 8'd11});
        send_pixel({8'd100, 8'd50, 8'd20, 8'd12});
    endtask

    // a write past the register list changes nothing
    task automatic test_unused_index();
        wait_drained();
        write_reg(REG_SPARE, 12'hFFF);
        send_pixel({8'd90, 8'd180, 8'd45, 8'd77});
    endtask

    // random registers per phase, random pixels, idling on both sides
    task automatic test_random_settings(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            apply_setting(pca_pkg::t_mode'($urandom_range(0, 7)), 9'($urandom), rand_gain());
            if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 12'($urandom));
            // some phases run with no idling at all
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < per_phase; n++) send_pixel(rand_pixel());
        end
    endtask

    // sender holds off mid-stream until every pending pixel is out
    task automatic test_drain_pause();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        for (int n = 0; n < 30; n++) send_pixel(rand_pixel());
        wait_drained();
        for (int n = 0; n < 30; n++) send_pixel(rand_pixel());
    endtask

    // full rate at the end, no gaps and no stalls
    task automatic test_back_to_back();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        apply_setting(pca_pkg::t_mode'($urandom_range(0, 7)), 9'($urandom), rand_gain());
        for (int n = 0; n < 190; n++) send_pixel(rand_pixel());
    endtask

    initial begin
        // synchronous reset, held from time zero
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_brightness();
        test_contrast();
        test_saturation();
        test_inversions();
        test_luma_modes();
        test_unused_index();
        test_random_settings(12, 115);
        test_drain_pause();
        test_back_to_back();

        // everything out, then the drain margin to catch stray output transactions
        wait_drained();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
